// ===== src/dbt_pkg.sv =====
// ----------------------------------------------------------------------------
// dbt_pkg
// shared types, register indexes, mode codes and helpers of the dct block
// dihedral transform
// ----------------------------------------------------------------------------
package dbt_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_BLOCKS_HIGH = 2'd0;
  localparam logic [1:0] REG_BLOCKS_WIDE = 2'd1;
  localparam logic [1:0] REG_MODE        = 2'd2;

  // request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // coefficient value width and block geometry
  localparam int VAL_W    = 16;
  localparam int SIDE_W   = 7;
  localparam int IDX_W    = 6;

  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_T_H    = 3'd1,
    MODE_H_V    = 3'd2,
    MODE_T_V    = 3'd3,
    MODE_H      = 3'd4,
    MODE_T_H_V  = 3'd5,
    MODE_V      = 3'd6,
    MODE_T      = 3'd7
  } dbt_mode_t;

  typedef struct packed {
    logic t;   // transpose
    logic hm;  // horizontal mirror
    logic vm;  // vertical mirror
  } dbt_xform_t;

  // per-request control carried from front to back
  typedef struct packed {
    logic is_read;
    logic oor;
    logic neg_h;
    logic neg_v;
  } dbt_ctl_t;

  // back end status for checking
  typedef struct packed {
    logic s1_valid;
    logic stall;
  } dbt_stat_t;

  function automatic dbt_xform_t decode_mode(input dbt_mode_t m);
    dbt_xform_t x;
    x = '0;
    case (m)
      MODE_NONE:  x = '{t: 1'b0, hm: 1'b0, vm: 1'b0};
      MODE_T_H:   x = '{t: 1'b1, hm: 1'b1, vm: 1'b0};
      MODE_H_V:   x = '{t: 1'b0, hm: 1'b1, vm: 1'b1};
      MODE_T_V:   x = '{t: 1'b1, hm: 1'b0, vm: 1'b1};
      MODE_H:     x = '{t: 1'b0, hm: 1'b1, vm: 1'b0};
      MODE_T_H_V: x = '{t: 1'b1, hm: 1'b1, vm: 1'b1};
      MODE_V:     x = '{t: 1'b0, hm: 1'b0, vm: 1'b1};
      MODE_T:     x = '{t: 1'b1, hm: 1'b0, vm: 1'b0};
      default:    x = '0;
    endcase
    return x;
  endfunction

  // two's complement negate, most negative value saturates
  function automatic logic [VAL_W-1:0] sat_neg(input logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] r;
    if (x == {1'b1, {(VAL_W-1){1'b0}}}) begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      r = (~x) + {{(VAL_W-1){1'b0}}, 1'b1};
    end
    return r;
  endfunction

endpackage

// ===== src/dbt_ram.sv =====
// ----------------------------------------------------------------------------
// dbt_ram
// generic single port ram, registered read data held while not reading
// ----------------------------------------------------------------------------
module dbt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/dbt_front.sv =====
// ----------------------------------------------------------------------------
// dbt_front
// takes requests, checks bounds and maps output coordinates back to the
// source layout address
// ----------------------------------------------------------------------------
module dbt_front #(
  parameter int SIDE = 64,
  parameter int AW   = 18
) (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [dbt_pkg::IDX_W-1:0]           in_block_row,
  input  logic [dbt_pkg::IDX_W-1:0]           in_block_col,
  input  logic [dbt_pkg::IDX_W-1:0]           in_coef_pos,
  input  logic signed [dbt_pkg::VAL_W-1:0]    in_value,
  input  logic [dbt_pkg::SIDE_W-1:0]          blocks_high,
  input  logic [dbt_pkg::SIDE_W-1:0]          blocks_wide,
  input  dbt_pkg::dbt_mode_t                  mode,
  output logic                                push_valid,
  input  logic                                push_ready,
  output dbt_pkg::dbt_ctl_t                   push_ctl,
  output logic [AW-1:0]                       push_addr,
  output logic [dbt_pkg::VAL_W-1:0]           push_value
);

  logic [dbt_pkg::SIDE_W-1:0] sh, sw, lim_r, lim_c, rr, cc, r_src, c_src;
  logic [dbt_pkg::IDX_W-1:0]  pos_src;
  dbt_pkg::dbt_xform_t        xf;
  logic                       is_read, oor;
  logic [31:0]                blk, addr_full;

  always_comb begin
    // dimensions in use are capped at the plane size
    sh = (32'(blocks_high) > SIDE) ? dbt_pkg::SIDE_W'(SIDE) : blocks_high;
    sw = (32'(blocks_wide) > SIDE) ? dbt_pkg::SIDE_W'(SIDE) : blocks_wide;
    is_read = (in_func == dbt_pkg::FUNC_READ);
    xf = is_read ? dbt_pkg::decode_mode(mode) : '0;
    lim_r = xf.t ? sw : sh;
    lim_c = xf.t ? sh : sw;
    oor = ({1'b0, in_block_row} >= lim_r) || ({1'b0, in_block_col} >= lim_c);
    // undo vmirror, hmirror, then transpose
    rr = xf.vm ? (lim_r - 7'd1 - {1'b0, in_block_row}) : {1'b0, in_block_row};
    cc = xf.hm ? (lim_c - 7'd1 - {1'b0, in_block_col}) : {1'b0, in_block_col};
    if (xf.t) begin
      r_src   = cc;
      c_src   = rr;
      pos_src = {in_coef_pos[2:0], in_coef_pos[5:3]};
    end else begin
      r_src   = rr;
      c_src   = cc;
      pos_src = in_coef_pos;
    end
    blk = 32'(r_src) * 32'(SIDE) + 32'(c_src);
    addr_full = (blk << dbt_pkg::IDX_W) | 32'(pos_src);
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_addr  = addr_full[AW-1:0];
  assign push_value = $unsigned(in_value);
  assign push_ctl   = '{is_read: is_read,
                        oor:     oor,
                        neg_h:   xf.hm & in_coef_pos[0],
                        neg_v:   xf.vm & in_coef_pos[3]};

endmodule

// ===== src/dbt_queue.sv =====
// ----------------------------------------------------------------------------
// dbt_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module dbt_queue #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/dbt_back.sv =====
// ----------------------------------------------------------------------------
// dbt_back
// issues queued requests to the coefficient ram, applies the negations and
// holds the result in an output register
// ----------------------------------------------------------------------------
module dbt_back #(
  parameter int AW = 18
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pop_valid,
  output logic                             pop_ready,
  input  dbt_pkg::dbt_ctl_t                pop_ctl,
  input  logic [AW-1:0]                    pop_addr,
  input  logic [dbt_pkg::VAL_W-1:0]        pop_value,
  output logic                             ram_we,
  output logic                             ram_re,
  output logic [AW-1:0]                    ram_addr,
  output logic [dbt_pkg::VAL_W-1:0]        ram_wdata,
  input  logic [dbt_pkg::VAL_W-1:0]        ram_rdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dbt_pkg::VAL_W-1:0] out_result_value,
  output logic                             out_out_of_range,
  output dbt_pkg::dbt_stat_t               stat
);

  logic                        s1_valid_r, s1_valid_nxt;
  dbt_pkg::dbt_ctl_t           s1_ctl_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [dbt_pkg::VAL_W-1:0]   out_value_r;
  logic                        out_oor_r;
  logic                        s1_adv, issue;
  logic [dbt_pkg::VAL_W-1:0]   res;

  assign s1_adv    = s1_valid_r & (~out_valid_r | out_ready);
  assign pop_ready = ~s1_valid_r | s1_adv;
  assign issue     = pop_valid & pop_ready;

  assign ram_we    = issue & ~pop_ctl.is_read & ~pop_ctl.oor;
  assign ram_re    = issue & pop_ctl.is_read & ~pop_ctl.oor;
  assign ram_addr  = pop_addr;
  assign ram_wdata = pop_value;

  always_comb begin
    res = ram_rdata;
    if (s1_ctl_r.neg_h) begin
      res = dbt_pkg::sat_neg(res);
    end
    if (s1_ctl_r.neg_v) begin
      res = dbt_pkg::sat_neg(res);
    end
    if (!s1_ctl_r.is_read || s1_ctl_r.oor) begin
      res = '0;
    end
    s1_valid_nxt  = issue ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ctl_r <= pop_ctl;
    end
    if (s1_adv) begin
      out_value_r <= res;
      out_oor_r   <= s1_ctl_r.oor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_value_r);
  assign out_out_of_range = out_oor_r;
  assign stat             = '{s1_valid: s1_valid_r, stall: s1_valid_r & ~s1_adv};

endmodule

// ===== src/dct_block_dihedral_transform.sv =====
// ----------------------------------------------------------------------------
// dct_block_dihedral_transform: dihedral transform of a plane of dct blocks
// path: request accept, queue entry, ram read stage, output register
// throughput: 1 request per cycle while out_ready keeps the output moving, set by the single port coefficient ram
// reset: sync active-low clears valid flags and queue pointers and sets the
// config registers to 64, 64, MODE_NONE; coefficient ram keeps contents and is undefined until written
// ----------------------------------------------------------------------------
module dct_block_dihedral_transform #(
  parameter int MAX_BLOCKS_SIDE = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [dbt_pkg::SIDE_W-1:0]       cfg_wdata,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [dbt_pkg::IDX_W-1:0]        in_block_row,
  input  logic [dbt_pkg::IDX_W-1:0]        in_block_col,
  input  logic [dbt_pkg::IDX_W-1:0]        in_coef_pos,
  input  logic signed [dbt_pkg::VAL_W-1:0] in_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dbt_pkg::VAL_W-1:0] out_result_value,
  output logic                             out_out_of_range
);

  // ram holds every block position of the largest plane, 64 coefficients each
  localparam int DEPTH = MAX_BLOCKS_SIDE * MAX_BLOCKS_SIDE * 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CTL_W = $bits(dbt_pkg::dbt_ctl_t);
  localparam int QW    = CTL_W + AW + dbt_pkg::VAL_W;

  // configuration registers
  logic [dbt_pkg::SIDE_W-1:0] blocks_high_r;
  logic [dbt_pkg::SIDE_W-1:0] blocks_wide_r;
  dbt_pkg::dbt_mode_t         mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_high_r <= 7'd64;
      blocks_wide_r <= 7'd64;
      mode_r        <= dbt_pkg::MODE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        dbt_pkg::REG_BLOCKS_HIGH: blocks_high_r <= cfg_wdata;
        dbt_pkg::REG_BLOCKS_WIDE: blocks_wide_r <= cfg_wdata;
        dbt_pkg::REG_MODE:        mode_r <= dbt_pkg::dbt_mode_t'(cfg_wdata[2:0]);
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // front: bounds check and inverse coordinate mapping
  logic                      f_push_valid, f_push_ready;
  dbt_pkg::dbt_ctl_t         f_ctl;
  logic [AW-1:0]             f_addr;
  logic [dbt_pkg::VAL_W-1:0] f_value;

  dbt_front #(
    .SIDE (MAX_BLOCKS_SIDE),
    .AW   (AW)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_block_row (in_block_row),
    .in_block_col (in_block_col),
    .in_coef_pos  (in_coef_pos),
    .in_value     (in_value),
    .blocks_high  (blocks_high_r),
    .blocks_wide  (blocks_wide_r),
    .mode         (mode_r),
    .push_valid   (f_push_valid),
    .push_ready   (f_push_ready),
    .push_ctl     (f_ctl),
    .push_addr    (f_addr),
    .push_value   (f_value)
  );

  // short queue decouples front from the ram / output side
  logic                      q_pop_valid, q_pop_ready;
  logic [QW-1:0]             q_pop_data;
  dbt_pkg::dbt_ctl_t         q_ctl;
  logic [AW-1:0]             q_addr;
  logic [dbt_pkg::VAL_W-1:0] q_value;

  dbt_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_data  ({f_ctl, f_addr, f_value}),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  assign {q_ctl, q_addr, q_value} = q_pop_data;

  // back: ram access, sign fixup, output register
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_addr;
  logic [dbt_pkg::VAL_W-1:0] ram_wdata, ram_rdata;
  dbt_pkg::dbt_stat_t        stat;

  dbt_back #(
    .AW (AW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (q_pop_valid),
    .pop_ready        (q_pop_ready),
    .pop_ctl          (q_ctl),
    .pop_addr         (q_addr),
    .pop_value        (q_value),
    .ram_we           (ram_we),
    .ram_re           (ram_re),
    .ram_addr         (ram_addr),
    .ram_wdata        (ram_wdata),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_out_of_range (out_out_of_range),
    .stat             (stat)
  );

  // coefficient store, source layout addressing
  dbt_ram #(
    .WIDTH (dbt_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // a held read stage must keep the ram idle so its read data survives
  a_stall_no_ram : assert property (@(posedge clk) disable iff (!rst_n)
    stat.stall |-> !ram_re && !ram_we)
    else $error("ram accessed while read stage is held");

  // a ram read always lands in the read stage
  a_read_lands : assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> stat.s1_valid)
    else $error("ram read issued without read stage entry");

  // a full queue means the back end has work
  a_full_has_work : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_pop_valid)
    else $error("request side blocked with empty queue");

  // out-of-range results carry a zero value
  a_oor_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_result_value == 16'sd0)
    else $error("out-of-range result with nonzero value");

endmodule
